// ===== hdl/dqs_pkg.sv =====
// Shared types and codes for the integer deque with search.
package dqs_pkg;

	localparam int DEPTH_DEF = 64;

	localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
	localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
	localparam logic [2:0] OP_POP_FRONT  = 3'd2;
	localparam logic [2:0] OP_POP_BACK   = 3'd3;
	localparam logic [2:0] OP_SEARCH     = 3'd4;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic [2:0]         op;
		logic signed [31:0] value;
	} dqs_req_t;

	typedef struct packed {
		logic signed [31:0] popped_value;
		logic               found;
		logic [1:0]         status;
		logic [6:0]         entry_count;
		logic signed [31:0] first_value;
		logic signed [31:0] last_value;
	} dqs_rsp_t;

endpackage

// ===== hdl/integer_deque_with_search.sv =====
// Bounded deque of signed 32-bit values in one synchronous RAM, with membership search.
// The result beat is registered at the accepting edge for a push, a dropped push, an empty
// or emptying pop, an empty search or an unused code; other pops pass through S_RDF or S_RDB
// first, as the new end value comes through the RAM read port. A search makes one RAM read per
// stored entry, stopping at the first match. Busy holds the next item off until the edge that
// takes the result. Reset clears head and count, not the RAM; no result stalls.
module integer_deque_with_search
	import dqs_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  dqs_req_t req,
	output logic     done,
	output dqs_rsp_t rsp
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W:0]   DEPTH_X  = (PTR_W + 1)'(DEPTH);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_RDF  = 2'd1;
	localparam logic [1:0] S_RDB  = 2'd2;
	localparam logic [1:0] S_SRCH = 2'd3;

	function automatic logic [PTR_W-1:0] add_wrap(input logic [PTR_W-1:0] a,
		input logic [PTR_W-1:0] b);
		logic [PTR_W:0] sum;
		sum = {1'b0, a} + {1'b0, b};
		if (sum >= DEPTH_X) begin
			sum = sum - DEPTH_X;
		end
		return sum[PTR_W-1:0];
	endfunction

	logic [31:0] mem [DEPTH];

	logic [1:0]       state_q, state_d;
	logic [PTR_W-1:0] head_q, head_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic [31:0]      first_q, first_d;
	logic [31:0]      last_q, last_d;
	logic [31:0]      popped_q, popped_d;
	logic [31:0]      key_q, key_d;
	logic [PTR_W-1:0] addr_q, addr_d;
	logic [CNT_W-1:0] iss_q, iss_d;
	logic             rv_q, rv_d;
	logic [31:0]      rd_data_q;

	logic             emit;
	logic             found_d;
	logic [1:0]       status_d;
	logic             mem_we, mem_re;
	logic [PTR_W-1:0] waddr, raddr;
	logic [31:0]      wdata;
	logic [CNT_W-1:0] cnt_dec;
	logic [31:0]      cnt_ext;

	assign busy = (state_q != S_IDLE);
	assign cnt_dec = count_q - CNT_W'(1);
	assign cnt_ext = 32'(count_d);

	always_comb begin
		state_d  = state_q;
		head_d   = head_q;
		count_d  = count_q;
		first_d  = first_q;
		last_d   = last_q;
		popped_d = popped_q;
		key_d    = key_q;
		addr_d   = addr_q;
		iss_d    = iss_q;
		rv_d     = 1'b0;
		emit     = 1'b0;
		found_d  = 1'b0;
		status_d = ST_OK;
		mem_we   = 1'b0;
		mem_re   = 1'b0;
		waddr    = head_q;
		raddr    = head_q;
		wdata    = req.value;
		case (state_q)
			S_IDLE: begin
				popped_d = '0;
				if (start) begin
					emit = 1'b1;
					case (req.op)
						OP_PUSH_FRONT, OP_PUSH_BACK: begin
							if (count_q == FULL_CNT) begin
								status_d = ST_FULL;
							end else begin
								mem_we  = 1'b1;
								count_d = count_q + CNT_W'(1);
								if (req.op == OP_PUSH_FRONT) begin
									waddr   = (head_q == '0) ? LAST_PTR : head_q - PTR_W'(1);
									head_d  = waddr;
									first_d = req.value;
									if (count_q == '0) begin
										last_d = req.value;
									end
								end else begin
									waddr  = add_wrap(head_q, count_q[PTR_W-1:0]);
									last_d = req.value;
									if (count_q == '0) begin
										first_d = req.value;
									end
								end
							end
						end
						OP_POP_FRONT, OP_POP_BACK: begin
							if (count_q == '0) begin
								status_d = ST_EMPTY;
							end else begin
								count_d = cnt_dec;
								if (req.op == OP_POP_FRONT) begin
									popped_d = first_q;
									head_d   = (head_q == LAST_PTR) ? '0 : head_q + PTR_W'(1);
									raddr    = head_d;
								end else begin
									popped_d = last_q;
									raddr    = add_wrap(head_q, cnt_dec[PTR_W-1:0] - PTR_W'(1));
								end
								// fetch the new end entry, then report
								if (cnt_dec != '0) begin
									emit    = 1'b0;
									mem_re  = 1'b1;
									state_d = (req.op == OP_POP_FRONT) ? S_RDF : S_RDB;
								end
							end
						end
						OP_SEARCH: begin
							if (count_q != '0) begin
								emit    = 1'b0;
								key_d   = req.value;
								addr_d  = head_q;
								iss_d   = '0;
								state_d = S_SRCH;
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_RDF: begin
				first_d = rd_data_q;
				emit    = 1'b1;
				state_d = S_IDLE;
			end
			S_RDB: begin
				last_d  = rd_data_q;
				emit    = 1'b1;
				state_d = S_IDLE;
			end
			S_SRCH: begin
				popped_d = '0;
				raddr    = addr_q;
				if (iss_q != count_q) begin
					mem_re = 1'b1;
					rv_d   = 1'b1;
					addr_d = (addr_q == LAST_PTR) ? '0 : addr_q + PTR_W'(1);
					iss_d  = iss_q + CNT_W'(1);
				end
				if (rv_q && rd_data_q == key_q) begin
					found_d = 1'b1;
					emit    = 1'b1;
					state_d = S_IDLE;
				end else if (iss_q == count_q && !rv_q) begin
					emit    = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q  <= '0;
			count_q <= '0;
			rv_q    <= 1'b0;
			iss_q   <= '0;
			done    <= 1'b0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			count_q <= count_d;
			rv_q    <= rv_d;
			iss_q   <= iss_d;
			done    <= emit;
		end
	end

	always_ff @(posedge clk) begin
		first_q  <= first_d;
		last_q   <= last_d;
		popped_q <= popped_d;
		key_q    <= key_d;
		addr_q   <= addr_d;
		if (emit) begin
			rsp.popped_value <= popped_d;
			rsp.found        <= found_d;
			rsp.status       <= status_d;
			rsp.entry_count  <= cnt_ext[6:0];
			rsp.first_value  <= (count_d == '0) ? '0 : first_d;
			rsp.last_value   <= (count_d == '0) ? '0 : last_d;
		end
	end

	// value store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[waddr] <= wdata;
		end
		if (mem_re) begin
			rd_data_q <= mem[raddr];
		end
	end

endmodule
